// ===== hdl/jvm_type_descriptor_parser_defines.svh =====
// ----------------------------------------------------------------------------
// JVM type descriptor parser assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef JVM_TYPE_DESCRIPTOR_PARSER_DEFINES_SVH
`define JVM_TYPE_DESCRIPTOR_PARSER_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define JTDP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jtdp assertion failed");

// next-cycle implication
`define JTDP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jtdp assertion failed");

`else

`define JTDP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define JTDP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/jtdp_pkg.sv =====
// ----------------------------------------------------------------------------
// JVM type descriptor parser package
// Character codes, result codes, payload types and a shared decode function.
// ----------------------------------------------------------------------------
package jtdp_pkg;

  localparam int unsigned REF_BYTES_DEF = 8;

  // descriptor characters
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_CLASS  = 8'h4C; // L
  localparam logic [7:0] CH_VOID   = 8'h56; // V
  localparam logic [7:0] CH_BOOL   = 8'h5A; // Z
  localparam logic [7:0] CH_BYTE   = 8'h42; // B
  localparam logic [7:0] CH_CHAR   = 8'h43; // C
  localparam logic [7:0] CH_SHORT  = 8'h53; // S
  localparam logic [7:0] CH_INT    = 8'h49; // I
  localparam logic [7:0] CH_FLOAT  = 8'h46; // F
  localparam logic [7:0] CH_LONG   = 8'h4A; // J
  localparam logic [7:0] CH_DOUBLE = 8'h44; // D

  // type codes
  localparam logic [3:0] TC_VOID   = 4'd0;
  localparam logic [3:0] TC_BOOL   = 4'd1;
  localparam logic [3:0] TC_BYTE   = 4'd2;
  localparam logic [3:0] TC_CHAR   = 4'd3;
  localparam logic [3:0] TC_SHORT  = 4'd4;
  localparam logic [3:0] TC_INT    = 4'd5;
  localparam logic [3:0] TC_FLOAT  = 4'd6;
  localparam logic [3:0] TC_LONG   = 4'd7;
  localparam logic [3:0] TC_DOUBLE = 4'd8;
  localparam logic [3:0] TC_REF    = 4'd9;

  // status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_CHAR   = 2'd1;
  localparam logic [1:0] ST_INCOMPLETE = 2'd2;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] type_code;
    logic       is_array;
    logic       is_method;
    logic [7:0] arg_count;
    logic [3:0] size_bytes;
  } res_t;

  // registered character handed to the parser core
  typedef struct packed {
    logic  valid;
    char_t chr;
  } stage_t;

  typedef struct packed {
    logic       is_base;
    logic [3:0] code;
  } base_t;

  function automatic base_t base_code(input logic [7:0] c);
    base_t b;
    b.is_base = 1'b1;
    unique case (c)
      CH_VOID:   b.code = TC_VOID;
      CH_BOOL:   b.code = TC_BOOL;
      CH_BYTE:   b.code = TC_BYTE;
      CH_CHAR:   b.code = TC_CHAR;
      CH_SHORT:  b.code = TC_SHORT;
      CH_INT:    b.code = TC_INT;
      CH_FLOAT:  b.code = TC_FLOAT;
      CH_LONG:   b.code = TC_LONG;
      CH_DOUBLE: b.code = TC_DOUBLE;
      default: begin
        b.is_base = 1'b0;
        b.code    = TC_VOID;
      end
    endcase
    return b;
  endfunction

endpackage

// ===== hdl/jtdp_char_if.sv =====
// ----------------------------------------------------------------------------
// Character channel
// Valid/ready channel carrying one descriptor character and its last flag.
// ----------------------------------------------------------------------------
interface jtdp_char_if;
  logic            valid;
  logic            ready;
  jtdp_pkg::char_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/jtdp_res_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one parse result.
// ----------------------------------------------------------------------------
interface jtdp_res_if;
  logic           valid;
  logic           ready;
  jtdp_pkg::res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/jtdp_in_reg.sv =====
// ----------------------------------------------------------------------------
// Input register
// Captures one character per transfer and holds it until the core takes it.
// ----------------------------------------------------------------------------
module jtdp_in_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  jtdp_char_if.sink        char_i,
  input  logic             take_i,
  output jtdp_pkg::stage_t stage_o
);
  import jtdp_pkg::*;

  logic  valid_q;
  char_t data_q;

  assign char_i.ready = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (char_i.ready) begin
      valid_q <= char_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (char_i.valid && char_i.ready) begin
      data_q <= char_i.data;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.chr   = data_q;

endmodule

// ===== hdl/jtdp_core.sv =====
// ----------------------------------------------------------------------------
// Parser core
// Descriptor phase machine; one character per cycle, a last one only with
// room in the result register; the result forms on the final character.
// ----------------------------------------------------------------------------
`include "jvm_type_descriptor_parser_defines.svh"

module jtdp_core #(
  parameter int unsigned RefBytes = jtdp_pkg::REF_BYTES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  jtdp_pkg::stage_t stage_i,
  input  logic             out_free_i,
  output logic             take_o,
  output logic             res_valid_o,
  output jtdp_pkg::res_t   res_o
);
  import jtdp_pkg::*;

  localparam logic [3:0] RefSize = 4'(RefBytes);

  typedef enum logic [2:0] {
    PH_START,
    PH_ARGS,
    PH_ARG_ARRAY,
    PH_ARG_CLASS,
    PH_TYPE,
    PH_TYPE_CLASS,
    PH_DONE,
    PH_ERROR
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] arg_total_q, arg_total_d;
  logic       method_q, method_d;
  logic       array_q, array_d;
  logic [3:0] found_q, found_d;

  logic [7:0] c;
  base_t      b;
  logic       last;
  logic [3:0] size;

  assign c    = stage_i.chr.ch;
  assign last = stage_i.chr.last;
  assign b    = base_code(c);

  assign take_o      = stage_i.valid && (!last || out_free_i);
  assign res_valid_o = take_o && last;

  always_comb begin
    phase_d     = phase_q;
    arg_total_d = arg_total_q;
    method_d    = method_q;
    array_d     = array_q;
    found_d     = found_q;
    unique case (phase_q)
      PH_START, PH_TYPE: begin
        if (phase_q == PH_START && c == CH_LPAREN) begin
          method_d = 1'b1;
          phase_d  = PH_ARGS;
        end else if (c == CH_LBRACK) begin
          array_d = 1'b1;
          phase_d = PH_TYPE;
        end else if (c == CH_CLASS) begin
          found_d = TC_REF;
          phase_d = PH_TYPE_CLASS;
        end else if (b.is_base) begin
          found_d = b.code;
          phase_d = PH_DONE;
        end else begin
          phase_d = PH_ERROR;
        end
      end
      PH_ARGS, PH_ARG_ARRAY: begin
        if (c == CH_RPAREN && phase_q == PH_ARGS) begin
          phase_d = PH_TYPE;
        end else if (c == CH_LBRACK) begin
          phase_d = PH_ARG_ARRAY;
        end else if (c == CH_CLASS) begin
          phase_d = PH_ARG_CLASS;
        end else if (b.is_base) begin
          if (arg_total_q != 8'hFF) arg_total_d = arg_total_q + 8'd1;
          phase_d = PH_ARGS;
        end else begin
          phase_d = PH_ERROR;
        end
      end
      PH_ARG_CLASS: begin
        if (c == CH_SEMI) begin
          if (arg_total_q != 8'hFF) arg_total_d = arg_total_q + 8'd1;
          phase_d = PH_ARGS;
        end
      end
      PH_TYPE_CLASS: begin
        if (c == CH_SEMI) phase_d = PH_DONE;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (found_d)
      TC_BOOL, TC_BYTE:   size = 4'd1;
      TC_CHAR, TC_SHORT:  size = 4'd2;
      TC_INT, TC_FLOAT:   size = 4'd4;
      TC_LONG, TC_DOUBLE: size = 4'd8;
      TC_REF:             size = RefSize;
      default:            size = 4'd0;
    endcase
  end

  always_comb begin
    res_o = '0;
    if (phase_d == PH_ERROR) begin
      res_o.status = ST_BAD_CHAR;
    end else if (phase_d != PH_DONE) begin
      res_o.status = ST_INCOMPLETE;
    end else begin
      res_o.status     = ST_OK;
      res_o.type_code  = found_d;
      res_o.is_array   = array_d;
      res_o.is_method  = method_d;
      res_o.arg_count  = arg_total_d;
      res_o.size_bytes = size;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      arg_total_q <= '0;
      method_q    <= 1'b0;
      array_q     <= 1'b0;
      found_q     <= TC_VOID;
    end else if (take_o) begin
      if (last) begin
        phase_q     <= PH_START;
        arg_total_q <= '0;
        method_q    <= 1'b0;
        array_q     <= 1'b0;
        found_q     <= TC_VOID;
      end else begin
        phase_q     <= phase_d;
        arg_total_q <= arg_total_d;
        method_q    <= method_d;
        array_q     <= array_d;
        found_q     <= found_d;
      end
    end
  end

  `JTDP_ASSERT_IMP(a_res_needs_room, clk_i, rst_ni, res_valid_o, out_free_i)
  `JTDP_ASSERT_NXT(a_reset_after_res, clk_i, rst_ni, res_valid_o,
                   phase_q == PH_START && arg_total_q == 8'd0 && !method_q)
  `JTDP_ASSERT_IMP(a_args_only_method, clk_i, rst_ni, arg_total_q != 8'd0, method_q)
  `JTDP_ASSERT_IMP(a_ok_code_range, clk_i, rst_ni,
                   res_valid_o && res_o.status == ST_OK, res_o.type_code <= TC_REF)

endmodule

// ===== hdl/jtdp_out_reg.sv =====
// ----------------------------------------------------------------------------
// Result register
// Holds one result until the result channel takes it.
// ----------------------------------------------------------------------------
module jtdp_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           res_valid_i,
  input  jtdp_pkg::res_t res_i,
  output logic           out_free_o,
  jtdp_res_if.source     res_o
);
  import jtdp_pkg::*;

  logic valid_q, valid_d;
  res_t data_q;

  assign out_free_o = !valid_q || res_o.ready;
  assign valid_d    = res_valid_i || (valid_q && !res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      data_q <= res_i;
    end
  end

  assign res_o.valid = valid_q;
  assign res_o.data  = data_q;

endmodule

// ===== hdl/jvm_type_descriptor_parser.sv =====
// ----------------------------------------------------------------------------
// JVM type descriptor parser
// Parses a field or method descriptor streamed one character per transfer
// and reports type, array/method flags, argument count and type size.
// ----------------------------------------------------------------------------
// One character is accepted every clock cycle, stalls aside. A character is
// captured in the input register, the parser core updates the descriptor
// phase from it, and on the character marked last the result is loaded
// into the result register, which offers it on the result channel. The
// phase update in the core sets the rate of one character per cycle; a
// full result register with no ready stalls only a last character, never
// the others.
module jvm_type_descriptor_parser #(
  parameter int unsigned RefBytes = jtdp_pkg::REF_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  jtdp_char_if.sink   char_i,
  jtdp_res_if.source  res_o
);
  import jtdp_pkg::*;

  stage_t stage;
  logic   take;
  logic   out_free;
  logic   res_valid;
  res_t   res;

  jtdp_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .char_i  (char_i),
    .take_i  (take),
    .stage_o (stage)
  );

  jtdp_core #(
    .RefBytes (RefBytes)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stage_i     (stage),
    .out_free_i  (out_free),
    .take_o      (take),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  jtdp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_free_o  (out_free),
    .res_o       (res_o)
  );

endmodule
